### rtl/core/pul_pkg.sv
`timescale 1ns / 1ps
package pul_pkg;

  localparam int MAX_N  = 20;
  localparam int LEN_W  = 5;
  localparam int ELEM_W = 5;
  localparam int RANK_W = 62;
  localparam int FACT_W = 62;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } pul_state_t;

  // load: fill the row with 0..MAX_N-1; remove: drop entry sel and close the gap
  typedef struct packed {
    logic              load;
    logic              remove;
    logic [ELEM_W-1:0] sel;
  } pul_pool_ctl_t;

  function automatic logic [FACT_W-1:0] fact_of(input logic [LEN_W-1:0] m);
    logic [FACT_W-1:0] f;
    case (m)
      5'd0:    f = 62'd1;
      5'd1:    f = 62'd1;
      5'd2:    f = 62'd2;
      5'd3:    f = 62'd6;
      5'd4:    f = 62'd24;
      5'd5:    f = 62'd120;
      5'd6:    f = 62'd720;
      5'd7:    f = 62'd5040;
      5'd8:    f = 62'd40320;
      5'd9:    f = 62'd362880;
      5'd10:   f = 62'd3628800;
      5'd11:   f = 62'd39916800;
      5'd12:   f = 62'd479001600;
      5'd13:   f = 62'd6227020800;
      5'd14:   f = 62'd87178291200;
      5'd15:   f = 62'd1307674368000;
      5'd16:   f = 62'd20922789888000;
      5'd17:   f = 62'd355687428096000;
      5'd18:   f = 62'd6402373705728000;
      5'd19:   f = 62'd121645100408832000;
      default: f = 62'd2432902008176640000;
    endcase
    return f;
  endfunction

endpackage

### rtl/core/pul_cell.sv
`timescale 1ns / 1ps
module pul_cell (
  input  logic                      clk,
  input  logic                      load,
  input  logic [pul_pkg::ELEM_W-1:0] load_val,
  input  logic                      shift,
  input  logic [pul_pkg::ELEM_W-1:0] nbr_val,
  output logic [pul_pkg::ELEM_W-1:0] val
);
  import pul_pkg::*;

  logic [ELEM_W-1:0] val_r;
  logic [ELEM_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (load) begin
      val_nxt = load_val;
    end else if (shift) begin
      val_nxt = nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

### rtl/core/pul_pool.sv
`timescale 1ns / 1ps
module pul_pool (
  input  logic                       clk,
  input  pul_pkg::pul_pool_ctl_t     ctl,
  output logic [pul_pkg::ELEM_W-1:0] sel_val
);
  import pul_pkg::*;

  logic [ELEM_W-1:0] cell_val [MAX_N];
  logic [ELEM_W-1:0] nbr_val  [MAX_N];

  for (genvar j = 0; j < MAX_N; j++) begin : g_cell
    if (j == MAX_N - 1) begin : g_tail
      assign nbr_val[j] = '0;
    end else begin : g_mid
      assign nbr_val[j] = cell_val[j + 1];
    end

    pul_cell u_cell (
      .clk      (clk),
      .load     (ctl.load),
      .load_val (ELEM_W'(j)),
      .shift    (ctl.remove && (ELEM_W'(j) >= ctl.sel)),
      .nbr_val  (nbr_val[j]),
      .val      (cell_val[j])
    );
  end

  // pick the selected entry of the remaining list
  always_comb begin
    sel_val = '0;
    for (int j = 0; j < MAX_N; j++) begin
      if (ctl.sel == ELEM_W'(j)) begin
        sel_val = sel_val | cell_val[j];
      end
    end
  end

endmodule

### rtl/core/permutation_unrank_lexicographic_top.sv
`timescale 1ns / 1ps
// Each item is decoded position by position: the digit of each position is found
// by the single 62-bit compare-subtract against the factorial table, one step per
// cycle; each element waits while the output is stalled, and a new item is
// accepted only after the last element of the current one has been emitted.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
module permutation_unrank_lexicographic_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [4:0] perm_length, [66:5] rank_index, [71:67] zero
  input  logic [pul_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [4:0] element, [7:5] zero
  output logic [pul_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  // [0] range_error
  output logic                           out_tuser
);
  import pul_pkg::*;

  pul_state_t        state_r, state_nxt;
  logic [RANK_W-1:0] k_r, k_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [ELEM_W-1:0] d_r, d_nxt;
  logic              bad_r, bad_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] out_elem_r, out_elem_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_err_r, out_err_nxt;

  logic [LEN_W-1:0]  in_len;
  logic [RANK_W-1:0] in_rank;
  logic [LEN_W-1:0]  n_sat;
  logic              in_fire;
  logic              can_sub;
  logic              out_free;
  logic              emit;
  logic [FACT_W-1:0] step_fact;
  logic [ELEM_W-1:0] pool_val;
  pul_pool_ctl_t     pool_ctl;

  assign in_len  = in_tdata[LEN_W-1:0];
  assign in_rank = in_tdata[LEN_W +: RANK_W];

  always_comb begin
    n_sat = in_len;
    if (in_len == '0) begin
      n_sat = LEN_W'(1);
    end else if (in_len > LEN_W'(MAX_N)) begin
      n_sat = LEN_W'(MAX_N);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign step_fact = fact_of(left_r - LEN_W'(1));
  assign can_sub   = !bad_r && (({1'b0, d_r} + 6'd1) < {1'b0, left_r}) && (k_r >= step_fact);
  assign out_free  = !out_valid_r || out_tready;
  assign emit      = (state_r == ST_RUN) && !can_sub && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit && left_r == LEN_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    k_nxt         = k_r;
    left_nxt      = left_r;
    d_nxt         = d_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    pool_ctl      = '{load: 1'b0, remove: 1'b0, sel: d_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          k_nxt         = in_rank;
          left_nxt      = n_sat;
          d_nxt         = '0;
          bad_nxt       = (in_rank >= fact_of(n_sat));
          pool_ctl.load = 1'b1;
        end
      end
      ST_RUN: begin
        if (can_sub) begin
          k_nxt = k_r - step_fact;
          d_nxt = d_r + ELEM_W'(1);
        end else if (emit) begin
          out_valid_nxt   = 1'b1;
          out_elem_nxt    = bad_r ? '0 : pool_val;
          out_last_nxt    = (left_r == LEN_W'(1));
          out_err_nxt     = bad_r;
          pool_ctl.remove = !bad_r;
          left_nxt        = left_r - LEN_W'(1);
          d_nxt           = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      left_r      <= LEN_W'(1);
      d_r         <= '0;
      bad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
      d_r         <= d_nxt;
      bad_r       <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    out_elem_r <= out_elem_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  pul_pool u_pool (
    .clk     (clk),
    .ctl     (pool_ctl),
    .sel_val (pool_val)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - ELEM_W)'(0), out_elem_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  a_digit_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (d_r < left_r))
    else $error("digit reached the size of the remaining list");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_RUN) && (d_r == '0))
    else $error("accepted item did not start a run");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && left_r == LEN_W'(1)) |=> (state_r == ST_IDLE) && out_tvalid && out_tlast)
    else $error("final position did not end the run with a marked result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("out-of-range result carries a nonzero element");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> !$past(emit))
    else $error("result overwritten before transfer");

endmodule
